[src/ster_pkg.sv]
`timescale 1ns / 1ps

package ster_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int POS_W      = 12;
    localparam int BTN_W      = 4;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MID     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP = 2'd3;

    localparam logic [7:0]  SLOW_RESET    = 8'd18;
    localparam logic [7:0]  MID_RESET     = 8'd14;
    localparam logic [7:0]  FAST_RESET    = 8'd9;
    localparam logic [15:0] STARTUP_RESET = 16'd1000;

    // run kinds, also the packet_kind field
    localparam logic KIND_TEST = 1'b0;
    localparam logic KIND_POS  = 1'b1;

    localparam logic [7:0] TEST_BYTE0 = 8'hA0;
    localparam logic [7:0] TEST_BYTE1 = 8'h04;
    localparam logic [7:0] TEST_FILL  = 8'h00;

    localparam logic [2:0] TEST_LAST_IDX = 3'd3;
    localparam logic [2:0] POS_LAST_IDX  = 3'd4;

    // one reply or packet waiting to be serialized
    typedef struct packed {
        logic             kind;
        logic             fast_baud;
        logic [7:0]       status;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
    } t_run;

endpackage

[src/ster_item_if.sv]
`timescale 1ns / 1ps

interface ster_item_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  rx_byte;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic [3:0]  press_mask;
    logic [3:0]  release_mask;

    modport source (
        output valid, func, rx_byte, pos_x, pos_y, press_mask, release_mask,
        input  ready
    );
    modport sink (
        input  valid, func, rx_byte, pos_x, pos_y, press_mask, release_mask,
        output ready
    );
endinterface

[src/ster_result_if.sv]
`timescale 1ns / 1ps

interface ster_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_fast_baud;
    logic       packet_kind;
    logic       last_of_run;

    modport source (
        output valid, tx_byte, tx_fast_baud, packet_kind, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, tx_byte, tx_fast_baud, packet_kind, last_of_run,
        output ready
    );
endinterface

[src/ster_front.sv]
`timescale 1ns / 1ps

module ster_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ster_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ster_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_take,
    input  logic [1:0]                          i_func,
    input  logic [7:0]                          i_rx_byte,
    input  logic [ster_pkg::POS_W-1:0]          i_pos_x,
    input  logic [ster_pkg::POS_W-1:0]          i_pos_y,
    input  logic [ster_pkg::BTN_W-1:0]          i_press_mask,
    input  logic [ster_pkg::BTN_W-1:0]          i_release_mask,
    output logic                                o_push,
    output ster_pkg::t_run                      o_run
);

    localparam logic [1:0] FUNC_HOST   = 2'd0;
    localparam logic [1:0] FUNC_BREAK  = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;
    localparam logic [1:0] FUNC_UPDATE = 2'd3;

    localparam logic [7:0] CMD_BAUD   = 8'h42; // B
    localparam logic [7:0] CMD_STREAM = 8'h52; // R
    localparam logic [7:0] CMD_SLOW   = 8'h4B; // K
    localparam logic [7:0] CMD_MID    = 8'h4C; // L
    localparam logic [7:0] CMD_FAST   = 8'h4D; // M
    localparam logic [7:0] CMD_POLL   = 8'h50; // P
    localparam logic [7:0] CMD_IDLE   = 8'h44; // D
    localparam logic [7:0] CMD_TEST   = 8'h54; // T

    localparam logic [1:0] RATE_SLOW = 2'd0;
    localparam logic [1:0] RATE_MID  = 2'd1;
    localparam logic [1:0] RATE_FAST = 2'd2;

    logic [7:0]  r_slow, r_mid, r_fast_p;
    logic [15:0] r_startup;

    logic                        r_test_done, n_test_done;
    logic                        r_stream, n_stream;
    logic                        r_fast_baud, n_fast_baud;
    logic [1:0]                  r_rate, n_rate;
    logic [7:0]                  r_tick, n_tick;
    logic [15:0]                 r_sc, n_sc;
    logic [ster_pkg::BTN_W-1:0]  r_held, n_held, r_pp, n_pp, r_pr, n_pr;
    logic [7:0]                  r_last, n_last;
    logic [ster_pkg::POS_W-1:0]  r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic [ster_pkg::POS_W-1:0]  r_rep_x, n_rep_x, r_rep_y, n_rep_y;

    logic [ster_pkg::BTN_W-1:0]  held1;
    logic [7:0]                  base_status;
    logic                        changed;
    logic [7:0]                  period_raw, period;
    logic [15:0]                 delay;
    logic [7:0]                  tick_next;
    logic [15:0]                 sc_next;
    logic                        do_test, do_report, polled, send;

    assign held1       = r_held | r_pp;
    assign base_status = {2'b01, 1'b0, held1, 1'b0};
    // bit 0 of each coordinate is noise and does not count as a change
    assign changed = (r_rep_x[ster_pkg::POS_W-1:1] != r_cur_x[ster_pkg::POS_W-1:1])
                  || (r_rep_y[ster_pkg::POS_W-1:1] != r_cur_y[ster_pkg::POS_W-1:1])
                  || (r_last[4:0] != base_status[4:0]);

    always_comb begin
        case (r_rate)
            RATE_MID:  period_raw = r_mid;
            RATE_FAST: period_raw = r_fast_p;
            default:   period_raw = r_slow;
        endcase
    end
    assign period    = (period_raw == 8'd0) ? 8'd1 : period_raw;
    assign delay     = (r_startup == 16'd0) ? 16'd1 : r_startup;
    assign tick_next = r_tick + 8'd1;
    assign sc_next   = (r_sc == 16'hFFFF) ? r_sc : r_sc + 16'd1;

    always_comb begin
        n_test_done = r_test_done;
        n_stream    = r_stream;
        n_fast_baud = r_fast_baud;
        n_rate      = r_rate;
        n_tick      = r_tick;
        n_sc        = r_sc;
        n_held      = r_held;
        n_pp        = r_pp;
        n_pr        = r_pr;
        n_last      = r_last;
        n_cur_x     = r_cur_x;
        n_cur_y     = r_cur_y;
        n_rep_x     = r_rep_x;
        n_rep_y     = r_rep_y;
        do_test     = 1'b0;
        do_report   = 1'b0;
        polled      = 1'b0;
        send        = 1'b0;
        o_push      = 1'b0;
        o_run       = '0;

        if (i_take) begin
            unique case (i_func)
                FUNC_HOST: begin
                    if (r_test_done) begin
                        unique case (i_rx_byte)
                            CMD_BAUD:   n_fast_baud = 1'b1;
                            CMD_STREAM: n_stream = 1'b1;
                            CMD_SLOW: begin
                                n_rate = RATE_SLOW;
                                n_tick = 8'd0;
                            end
                            CMD_MID: begin
                                n_rate = RATE_MID;
                                n_tick = 8'd0;
                            end
                            CMD_FAST: begin
                                if (r_fast_baud) begin
                                    n_rate = RATE_FAST;
                                    n_tick = 8'd0;
                                end
                            end
                            CMD_POLL: begin
                                do_report = 1'b1;
                                polled    = 1'b1;
                                n_stream  = 1'b0;
                            end
                            CMD_IDLE:   n_stream = 1'b0;
                            CMD_TEST:   do_test = 1'b1;
                            default: ;
                        endcase
                    end
                end
                FUNC_BREAK: do_test = r_test_done;
                FUNC_TICK: begin
                    if (tick_next >= period) begin
                        n_tick    = 8'd0;
                        do_report = r_test_done && r_stream;
                    end else begin
                        n_tick = tick_next;
                    end
                    if (!r_test_done) begin
                        n_sc    = sc_next;
                        do_test = (sc_next >= delay);
                    end
                end
                FUNC_UPDATE: begin
                    n_cur_x = i_pos_x;
                    n_cur_y = i_pos_y;
                    n_pp    = r_pp | i_press_mask;
                    n_pr    = r_pr | i_release_mask;
                end
                default: ;
            endcase
        end

        // a report and a self test never come from the same item
        if (do_report) begin
            send   = polled || changed;
            n_held = held1 & ~r_pr;
            n_pp   = '0;
            n_pr   = '0;
            n_last = {send, base_status[6:0]};
            if (send) begin
                o_push          = 1'b1;
                o_run.kind      = ster_pkg::KIND_POS;
                o_run.fast_baud = r_fast_baud;
                o_run.status    = {send, base_status[6:0]};
                o_run.x         = r_cur_x;
                o_run.y         = r_cur_y;
                n_rep_x         = r_cur_x;
                n_rep_y         = r_cur_y;
            end
        end
        if (do_test) begin
            o_push          = 1'b1;
            o_run.kind      = ster_pkg::KIND_TEST;
            o_run.fast_baud = 1'b0;
            n_fast_baud     = 1'b0;
            n_stream        = 1'b0;
            n_cur_x         = '0;
            n_cur_y         = '0;
            n_rep_x         = '0;
            n_rep_y         = '0;
            n_last          = '0;
            n_held          = '0;
            n_pp            = '0;
            n_pr            = '0;
            n_rate          = RATE_SLOW;
            n_tick          = 8'd0;
            n_test_done     = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slow    <= ster_pkg::SLOW_RESET;
            r_mid     <= ster_pkg::MID_RESET;
            r_fast_p  <= ster_pkg::FAST_RESET;
            r_startup <= ster_pkg::STARTUP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ster_pkg::CFG_SLOW:    r_slow    <= i_cfg_data[7:0];
                ster_pkg::CFG_MID:     r_mid     <= i_cfg_data[7:0];
                ster_pkg::CFG_FAST:    r_fast_p  <= i_cfg_data[7:0];
                ster_pkg::CFG_STARTUP: r_startup <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_test_done <= 1'b0;
            r_stream    <= 1'b0;
            r_fast_baud <= 1'b0;
            r_rate      <= RATE_SLOW;
            r_tick      <= 8'd0;
            r_sc        <= 16'd0;
            r_held      <= '0;
            r_pp        <= '0;
            r_pr        <= '0;
            r_last      <= 8'd0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_rep_x     <= '0;
            r_rep_y     <= '0;
        end else begin
            r_test_done <= n_test_done;
            r_stream    <= n_stream;
            r_fast_baud <= n_fast_baud;
            r_rate      <= n_rate;
            r_tick      <= n_tick;
            r_sc        <= n_sc;
            r_held      <= n_held;
            r_pp        <= n_pp;
            r_pr        <= n_pr;
            r_last      <= n_last;
            r_cur_x     <= n_cur_x;
            r_cur_y     <= n_cur_y;
            r_rep_x     <= n_rep_x;
            r_rep_y     <= n_rep_y;
        end
    end

endmodule

[src/ster_queue.sv]
`timescale 1ns / 1ps

module ster_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ster_pkg::t_run i_run,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output ster_pkg::t_run o_run
);

    ster_pkg::t_run r_mem [2];
    logic           r_wr, r_rd;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_run   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[src/ster_back.sv]
`timescale 1ns / 1ps

module ster_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ster_pkg::t_run i_run,
    output logic           o_pop,
    ster_result_if.source  o_result
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_baud, r_kind, r_last;

    logic       load;
    logic       is_last;
    logic [7:0] sel_byte;

    assign load    = i_valid && (!r_valid || o_result.ready);
    assign is_last = (i_run.kind == ster_pkg::KIND_POS) ? (r_idx == ster_pkg::POS_LAST_IDX)
                                                        : (r_idx == ster_pkg::TEST_LAST_IDX);
    assign o_pop   = load && is_last;

    always_comb begin
        if (i_run.kind == ster_pkg::KIND_POS) begin
            case (r_idx)
                3'd0:    sel_byte = i_run.status;
                3'd1:    sel_byte = {2'b00, i_run.x[5:0]};
                3'd2:    sel_byte = {2'b00, i_run.x[11:6]};
                3'd3:    sel_byte = {2'b00, i_run.y[5:0]};
                default: sel_byte = {2'b00, i_run.y[11:6]};
            endcase
        end else begin
            case (r_idx)
                3'd0:    sel_byte = ster_pkg::TEST_BYTE0;
                3'd1:    sel_byte = ster_pkg::TEST_BYTE1;
                default: sel_byte = ster_pkg::TEST_FILL;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_baud <= i_run.fast_baud;
            r_kind <= i_run.kind;
            r_last <= is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 3'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? 3'd0 : r_idx + 3'd1;
            end else if (o_result.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid        = r_valid;
    assign o_result.tx_byte      = r_byte;
    assign o_result.tx_fast_baud = r_baud;
    assign o_result.packet_kind  = r_kind;
    assign o_result.last_of_run  = r_last;

endmodule

[src/serial_tablet_report_engine_unit.sv]
`timescale 1ns / 1ps

// Serial tablet report engine.
// i_item carries one event per item: a host command byte, a line break, a
// millisecond tick or a pointer update. o_result carries one byte to the
// host per item, tagged with its line speed, its run kind (self-test reply
// or position packet) and a flag on the final byte of each run.
// The configuration port writes the three report periods and the startup
// delay, one register per cycle with i_cfg_we high.
// The front accepts one item per cycle while its two-entry run queue has
// room; an item that causes nothing is still taken. The first byte of a
// run is registered in the queue and then in the serializer's output
// register, and the serializer sends one byte per cycle while o_result is
// ready: four for a self-test reply, five for a position packet, so the
// byte output sets the pace. When the receiver stalls, the current byte
// holds, the queue fills, and i_item.ready drops while the queue holds
// two runs, the run being sent counted until its last byte is loaded for
// output. Synchronous reset restores the default periods and clears all
// control state; the first self test follows the startup delay in ticks.
module serial_tablet_report_engine_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ster_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [ster_pkg::CFG_DATA_W-1:0] i_cfg_data,
    ster_item_if.sink                       i_item,
    ster_result_if.source                   o_result
);

    logic           push, pop, full, q_valid, take;
    ster_pkg::t_run run_in, run_out;

    assign i_item.ready = !full;
    assign take         = i_item.valid && !full;

    ster_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_take         (take),
        .i_func         (i_item.func),
        .i_rx_byte      (i_item.rx_byte),
        .i_pos_x        (i_item.pos_x),
        .i_pos_y        (i_item.pos_y),
        .i_press_mask   (i_item.press_mask),
        .i_release_mask (i_item.release_mask),
        .o_push         (push),
        .o_run          (run_in)
    );

    ster_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run_in),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (q_valid),
        .o_run   (run_out)
    );

    ster_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_run    (run_out),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule

[src/ster_checker.sv]
`timescale 1ns / 1ps

module ster_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_tx_byte,
    input logic       i_tx_fast_baud,
    input logic       i_packet_kind,
    input logic       i_last_of_run
);

    // a stalled byte stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_tx_byte))
        else $error("result byte changed while stalled");

    // self-test replies always go out at the slow line speed
    a_test_slow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_packet_kind == ster_pkg::KIND_TEST) |-> !i_tx_fast_baud)
        else $error("self-test byte at fast baud");

    a_test_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_packet_kind == ster_pkg::KIND_TEST) && i_last_of_run
        |-> (i_tx_byte == ster_pkg::TEST_FILL))
        else $error("self-test reply ends in a nonzero byte");

    // coordinate bytes carry six bits
    a_pos_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_packet_kind == ster_pkg::KIND_POS) && i_last_of_run
        |-> (i_tx_byte[7:6] == 2'b00))
        else $error("position packet ends in a wide byte");

endmodule

bind serial_tablet_report_engine_unit ster_checker u_ster_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_result.valid),
    .i_out_ready    (o_result.ready),
    .i_tx_byte      (o_result.tx_byte),
    .i_tx_fast_baud (o_result.tx_fast_baud),
    .i_packet_kind  (o_result.packet_kind),
    .i_last_of_run  (o_result.last_of_run)
);
